/* design/nbge_pkg.sv */
// package for the gridding engine: request codes, widths, controller types
// used by the controller, datapath and top level; no dependencies
package nbge_pkg;

  localparam int unsigned GridSideDef    = 16;
  localparam int unsigned ChannelsDef    = 4;
  localparam int unsigned BasisCoeffsDef = 4;
  localparam int unsigned BasisRowsDef   = 256;

  localparam int unsigned CellW = 32;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_SCATTER = 3'd1,
    REQ_GATHER  = 3'd2,
    REQ_READ    = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e;

  typedef enum logic [0:0] {
    CFG_ROWS   = 1'b0,
    CFG_COEFFS = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_WR,
    ST_RND,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic mod_step;  // one restoring step of spoke mod rows
    logic issue_rd;  // issue basis and cell reads for the selected coefficient
    logic mul;       // register the products
    logic acc;       // accumulate or compute new cell value
    logic wr;        // write back the cell
    logic next_b;    // advance coefficient index
    logic wipe;      // clearing pass write
    logic rnd;       // gather rounding
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic last_b;
    logic wipe_done;
    logic in_range;
  } sts_t;

endpackage

/* design/nbge_ram.sv */
// generic single port ram with registered read
// no dependencies
module nbge_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/nbge_ctrl.sv */
// controller state machine of the gridding engine
// depends on nbge_pkg
module nbge_ctrl import nbge_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic [2:0] req_i,
  input  logic out_free_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  req_e   req_q, req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIPE;
      req_q   <= REQ_LOAD;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.wipe_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (in_fire_i) begin
          cmd_o.capture = 1'b1;
          req_d   = req_e'(req_i);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          unique case (req_q)
            REQ_LOAD: begin
              cmd_o.wr = 1'b1;
              state_d  = ST_IDLE;
            end
            REQ_SCATTER, REQ_CLEAR: state_d = sts_i.in_range ? ST_RD : ST_IDLE;
            REQ_GATHER, REQ_READ:   state_d = sts_i.in_range ? ST_RD : ST_OUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        cmd_o.issue_rd = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        unique case (req_q)
          REQ_SCATTER, REQ_CLEAR: state_d = ST_WR;
          REQ_READ: state_d = ST_OUT;
          default: begin
            cmd_o.next_b = 1'b1;
            state_d = sts_i.last_b ? ST_RND : ST_RD;
          end
        endcase
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        cmd_o.next_b = 1'b1;
        state_d = (sts_i.last_b || req_q == REQ_CLEAR) ? ST_IDLE : ST_RD;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* design/nbge_dp.sv */
// datapath: config registers, basis and grid memories, arithmetic, output stage
// depends on nbge_pkg and nbge_ram
module nbge_dp import nbge_pkg::*; #(
  parameter int unsigned GridSide    = GridSideDef,
  parameter int unsigned Channels    = ChannelsDef,
  parameter int unsigned BasisCoeffs = BasisCoeffsDef,
  parameter int unsigned BasisRows   = BasisRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_fire_i,
  input  logic        cfg_addr_i,
  input  logic [8:0]  cfg_data_i,
  input  logic [2:0]  req_i,
  input  logic [1:0]  channel_i,
  input  logic [3:0]  grid_x_i,
  input  logic [3:0]  grid_y_i,
  input  logic [3:0]  grid_z_i,
  input  logic [15:0] spoke_i,
  input  logic [1:0]  coeff_i,
  input  logic signed [15:0] s_re_i,
  input  logic signed [15:0] s_im_i,
  input  logic [15:0] weight_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_pop_i,
  output logic        out_valid_o,
  output logic [65:0] out_data_o
);
  localparam int unsigned BW     = (BasisCoeffs > 1) ? $clog2(BasisCoeffs) : 1;
  localparam int unsigned RowW   = (BasisRows > 1) ? $clog2(BasisRows) : 1;
  localparam int unsigned CellsN = Channels * BasisCoeffs * GridSide * GridSide * GridSide;
  localparam int unsigned CAW    = $clog2(CellsN);
  localparam int unsigned TabN   = BasisRows * BasisCoeffs;
  localparam int unsigned TAW    = (TabN > 1) ? $clog2(TabN) : 1;
  localparam int unsigned RegRW  = $clog2(BasisRows + 1);
  localparam int unsigned RegBW  = $clog2(BasisCoeffs + 1);
  localparam logic [63:0] Max32  = 64'sd2147483647;
  localparam logic [63:0] Min32  = -64'sd2147483648;

  // configuration registers, clamped on write
  logic [RegRW-1:0] rows_q;
  logic [RegBW-1:0] coeffs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= RegRW'(1);
      coeffs_q <= RegBW'(1);
    end else if (cfg_fire_i) begin
      if (cfg_addr_i == CFG_ROWS) begin
        if (cfg_data_i == 9'd0) rows_q <= RegRW'(1);
        else if (32'(cfg_data_i) > BasisRows) rows_q <= RegRW'(BasisRows);
        else rows_q <= RegRW'(cfg_data_i);
      end else begin
        if (cfg_data_i[2:0] == 3'd0) coeffs_q <= RegBW'(1);
        else if (32'(cfg_data_i[2:0]) > BasisCoeffs) coeffs_q <= RegBW'(BasisCoeffs);
        else coeffs_q <= RegBW'(cfg_data_i[2:0]);
      end
    end
  end

  // captured item
  logic [2:0]  req_q;
  logic [1:0]  ch_q, col_q;
  logic [3:0]  x_q, y_q, z_q;
  logic [15:0] spoke_q, w_q;
  logic signed [15:0] sre_q, sim_q;
  logic        rng_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i; ch_q <= channel_i; col_q <= coeff_i;
      x_q <= grid_x_i; y_q <= grid_y_i; z_q <= grid_z_i;
      spoke_q <= spoke_i; w_q <= weight_i; sre_q <= s_re_i; sim_q <= s_im_i;
    end
  end

  // spoke mod rows: restoring, one quotient bit per cycle
  logic [24:0] rem_q;
  logic [4:0]  mcnt_q;
  logic [24:0] trial;
  assign trial = {rem_q[23:0], spoke_q[15 - mcnt_q[3:0]]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rem_q  <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mod_step && !mcnt_q[4]) begin
      rem_q  <= (trial >= 25'(rows_q)) ? trial - 25'(rows_q) : trial;
      mcnt_q <= mcnt_q + 5'd1;
    end
  end
  assign sts_o.mod_done = mcnt_q[4];

  // range checks
  logic rng_cell, rng_col;
  always_comb begin
    rng_cell = 32'(ch_q) < Channels && 32'(x_q) < GridSide &&
               32'(y_q) < GridSide && 32'(z_q) < GridSide;
    rng_col  = 32'(col_q) < BasisCoeffs;
    rng_q    = (req_q == REQ_READ || req_q == REQ_CLEAR) ? (rng_cell && rng_col) : rng_cell;
  end
  assign sts_o.in_range = rng_q;

  // coefficient counter
  logic [BW-1:0] b_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) b_q <= '0;
    else if (cmd_i.next_b) b_q <= b_q + BW'(1);
  end
  assign sts_o.last_b = (32'(b_q) + 1 >= 32'(coeffs_q));

  logic [BW-1:0] bsel;
  assign bsel = (req_q == REQ_READ || req_q == REQ_CLEAR) ? BW'(col_q) : b_q;

  // clearing pass counter
  logic [CAW:0] wcnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wcnt_q <= '0;
    else if (cmd_i.wipe && !wcnt_q[CAW]) wcnt_q <= wcnt_q + 1'b1;
  end
  assign sts_o.wipe_done = wcnt_q[CAW];

  // basis table
  logic          tab_we;
  logic [TAW-1:0] tab_addr;
  logic [15:0]   tab_rd;
  logic [RowW-1:0] row;
  assign tab_we = cmd_i.wr && req_q == REQ_LOAD && 32'(spoke_q) < 32'(rows_q) &&
                  32'(col_q) < BasisCoeffs;
  assign row = tab_we ? RowW'(spoke_q) : RowW'(rem_q);
  assign tab_addr = TAW'(32'(row) * BasisCoeffs + 32'(tab_we ? BW'(col_q) : bsel));
  nbge_ram #(.Width(16), .Depth(TabN)) u_tab (
    .clk_i, .we_i(tab_we), .addr_i(tab_addr), .wdata_i(sre_q), .rdata_o(tab_rd)
  );

  // grid store
  logic           grid_we;
  logic [CAW-1:0] cell_addr, grid_addr;
  logic [63:0]    grid_wd, grid_rd, new_q;
  assign cell_addr = CAW'(((((32'(ch_q) * BasisCoeffs + 32'(bsel)) * GridSide + 32'(x_q))
                      * GridSide + 32'(y_q)) * GridSide) + 32'(z_q));
  assign grid_we   = cmd_i.wipe ? !wcnt_q[CAW] : (cmd_i.wr && req_q != REQ_LOAD);
  assign grid_addr = cmd_i.wipe ? wcnt_q[CAW-1:0] : cell_addr;
  assign grid_wd   = (cmd_i.wipe || req_q == REQ_CLEAR) ? 64'd0 : new_q;
  nbge_ram #(.Width(64), .Depth(CellsN)) u_grid (
    .clk_i, .we_i(grid_we), .addr_i(grid_addr), .wdata_i(grid_wd), .rdata_o(grid_rd)
  );

  // products: scatter uses s*w then *basis, all other requests use cell*basis
  logic signed [32:0] swr_q, swi_q;
  logic signed [63:0] pr_q, pi_q;
  logic signed [15:0] bv;
  logic signed [31:0] cre, cim;
  assign bv  = tab_rd;
  assign cre = grid_rd[31:0];
  assign cim = grid_rd[63:32];
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_step) begin
      swr_q <= 33'(sre_q * $signed({1'b0, w_q}));
      swi_q <= 33'(sim_q * $signed({1'b0, w_q}));
    end
    if (cmd_i.mul) begin
      if (req_q == REQ_SCATTER) begin
        pr_q <= 64'(swr_q * bv);
        pi_q <= 64'(swi_q * bv);
      end else begin
        pr_q <= 64'(cre * bv);
        pi_q <= 64'(cim * bv);
      end
    end
  end

  // saturation helper
  function automatic logic [32:0] sat(input logic signed [63:0] v);
    if (v > $signed(Max32)) sat = {1'b1, 32'h7fffffff};
    else if (v < $signed(Min32)) sat = {1'b1, 32'h80000000};
    else sat = {1'b0, v[31:0]};
  endfunction

  // accumulate, write-back value, rounding
  logic signed [63:0] accr_q, acci_q;
  logic [31:0] vre_q, vim_q;
  logic sat_q;
  logic signed [63:0] tr, ti;
  logic [32:0] sr, si;
  always_comb begin
    tr = 64'(cre) + ((pr_q + 64'sd268435456) >>> 29);
    ti = 64'(cim) + ((pi_q + 64'sd268435456) >>> 29);
    if (cmd_i.rnd) begin
      tr = (accr_q + 64'sd16384) >>> 15;
      ti = (acci_q + 64'sd16384) >>> 15;
    end
    sr = sat(tr);
    si = sat(ti);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sat_q <= 1'b0;
    else if ((cmd_i.acc && req_q == REQ_SCATTER) || cmd_i.rnd)
      sat_q <= sat_q | sr[32] | si[32];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      accr_q <= '0; acci_q <= '0; vre_q <= '0; vim_q <= '0;
    end
    if (cmd_i.acc) begin
      accr_q <= accr_q + pr_q;
      acci_q <= acci_q + pi_q;
      new_q  <= {si[31:0], sr[31:0]};
      if (req_q == REQ_READ) begin
        vre_q <= cre; vim_q <= cim;
      end
    end
    if (cmd_i.rnd) begin
      vre_q <= sr[31:0]; vim_q <= si[31:0];
    end
  end

  // output register
  logic        ov_q;
  logic [65:0] od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.load_out) ov_q <= 1'b1;
    else if (out_pop_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) od_q <= {sat_q, req_q == REQ_READ, vim_q, vre_q};
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule

/* design/nn_basis_gridding_engine_unit.sv */
// Gridding engine with a temporal basis. After reset a clearing pass zeroes
// the grid memory, one cell per cycle (CHANNELS*BASIS_COEFFS*GRID_SIDE^3
// cells, 65536 by default) while s_axis_tready stays low. After its accept
// cycle each item reduces the spoke modulo the row count (16 remainder
// steps, one bit per cycle, then a done check). Scatter and gather then
// make one pass per coefficient in use through the single-port grid memory
// (read, multiply, accumulate), plus one write per coefficient for scatter;
// read takes one such pass, clear one pass plus its write. Gather adds a
// rounding step and every result an output step; a load ends with its
// table write once the spoke reduction is done.
// Results wait in an output register.
// depends on nbge_pkg, nbge_ctrl, nbge_dp
module nn_basis_gridding_engine_unit import nbge_pkg::*; #(
  parameter int unsigned GridSide    = GridSideDef,
  parameter int unsigned Channels    = ChannelsDef,
  parameter int unsigned BasisCoeffs = BasisCoeffsDef,
  parameter int unsigned BasisRows   = BasisRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[2:0] channel[4:3] grid_x[8:5] grid_y[12:9] grid_z[16:13]
  // spoke_index[32:17] coeff_index[34:33] sample_re[50:35] sample_im[66:51]
  // weight[82:67], zero fill to 88
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value_re[31:0] value_im[63:32]
  output logic [63:0] m_axis_tdata,
  // result_kind[0] saturated[1]
  output logic [1:0]  m_axis_tuser
);
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_pop;
  logic [65:0] od;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign out_pop = m_axis_tvalid && m_axis_tready;

  nbge_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .req_i(s_axis_tdata[2:0]),
    .out_free_i(!m_axis_tvalid), .sts_i(sts), .busy_o(busy), .cmd_o(cmd)
  );

  nbge_dp #(
    .GridSide(GridSide), .Channels(Channels),
    .BasisCoeffs(BasisCoeffs), .BasisRows(BasisRows)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_fire_i(cfg_valid_i), .cfg_addr_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .req_i(s_axis_tdata[2:0]), .channel_i(s_axis_tdata[4:3]),
    .grid_x_i(s_axis_tdata[8:5]), .grid_y_i(s_axis_tdata[12:9]),
    .grid_z_i(s_axis_tdata[16:13]), .spoke_i(s_axis_tdata[32:17]),
    .coeff_i(s_axis_tdata[34:33]), .s_re_i(s_axis_tdata[50:35]),
    .s_im_i(s_axis_tdata[66:51]), .weight_i(s_axis_tdata[82:67]),
    .cmd_i(cmd), .sts_o(sts), .out_pop_i(out_pop),
    .out_valid_o(m_axis_tvalid), .out_data_o(od)
  );

  assign m_axis_tdata = od[63:0];
  assign m_axis_tuser = od[65:64];
endmodule

/* design/nbge_checker.sv */
// port-level checks of the gridding engine, bound to the top level
// depends on nn_basis_gridding_engine_unit
module nbge_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  // one item at a time: no accept in the cycle after an accept
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back accept");
  // saturation flag is sticky
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[1] ##1 m_axis_tvalid |-> m_axis_tuser[1])
    else $error("sat flag dropped");
  // no result appears straight after an item is accepted
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready)) else $error("early result");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
endmodule

bind nn_basis_gridding_engine_unit nbge_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
